// ===== rtl/divider_timer_with_overflow_reload_core_defines.svh =====
// Assertion macros used by the checker of the divider timer.
`ifndef DIVIDER_TIMER_WITH_OVERFLOW_RELOAD_CORE_DEFINES_SVH
`define DIVIDER_TIMER_WITH_OVERFLOW_RELOAD_CORE_DEFINES_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define DTR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer check failed: same-cycle implication");

// Next-cycle implication: the consequent must hold the cycle after the antecedent.
`define DTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer check failed: next-cycle implication");

`endif

// ===== rtl/dtr_pkg.sv =====
// Types, constants and helper functions of the divider timer.
package dtr_pkg;

   // Transaction kinds carried on the request channel
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } dtr_op_type;

   // Register map
   localparam logic [15:0] ADDR_DIV_LO  = 16'hFF03;
   localparam logic [15:0] ADDR_DIV_HI  = 16'hFF04;
   localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
   localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
   localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

   localparam logic [15:0] DIVIDER_RESET  = 16'hAB00;
   localparam logic [7:0]  READ_IDLE      = 8'hFF;
   localparam logic [7:0]  COUNTER_MAX    = 8'hFF;
   localparam int unsigned CTRL_ENABLE    = 2;
   localparam logic [2:0]  TICK_RELOAD    = 3'd4;
   localparam logic [2:0]  TICK_RESUME    = 3'd5;

   // Architectural state of the timer
   typedef struct packed {
      logic [15:0] divider;
      logic [7:0]  counter;
      logic [7:0]  modulo;
      logic [2:0]  control;
      logic        prior_gate;
      logic        in_overflow;
      logic [2:0]  overflow_ticks;
   } dtr_state_type;

   localparam dtr_state_type STATE_RESET = '{
      divider:        DIVIDER_RESET,
      counter:        8'h00,
      modulo:         8'h00,
      control:        3'b000,
      prior_gate:     1'b0,
      in_overflow:    1'b0,
      overflow_ticks: 3'd0
   };

   // Result of one transaction
   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_request;
   } dtr_result_type;

   // Divider bit watched by the gate for each select code
   function automatic logic [3:0] sel_index(input logic [1:0] sel);
      logic [3:0] idx;
      case (sel)
         2'd0:    idx = 4'd9;
         2'd1:    idx = 4'd3;
         2'd2:    idx = 4'd5;
         default: idx = 4'd7;
      endcase
      return idx;
   endfunction

endpackage

// ===== rtl/dtr_chan_if.sv =====
// Valid/ready channel interfaces for requests and responses of the divider timer.
interface dtr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] addr;
   logic [7:0]  write_data;

   modport source (output valid, output op, output addr, output write_data, input ready);
   modport sink   (input valid, input op, input addr, input write_data, output ready);
endinterface

interface dtr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       irq_request;

   modport source (output valid, output read_data, output irq_request, input ready);
   modport sink   (input valid, input read_data, input irq_request, output ready);
endinterface

// ===== rtl/dtr_step.sv =====
// Single-pass next-state and response logic of the divider timer.
module dtr_step
   import dtr_pkg::*;
(
   input  logic [1:0]     op,
   input  logic [15:0]    addr,
   input  logic [7:0]     write_data,
   input  dtr_state_type  state_in,
   output dtr_state_type  state_out,
   output dtr_result_type result
);

   dtr_state_type pre;
   dtr_state_type nxt;
   logic          do_step;
   logic          sel_bit;
   logic          gate;
   logic [2:0]    ticks;
   logic [7:0]    rd;
   logic          irq;

   always_comb begin
      pre     = state_in;
      do_step = 1'b0;
      rd      = READ_IDLE;

      // Decode the transaction and apply register side effects
      case (op)
         OP_TICK: begin
            pre.divider = state_in.divider + 16'd1;
            do_step     = 1'b1;
         end
         OP_READ: begin
            case (addr)
               ADDR_DIV_LO:  rd = state_in.divider[7:0];
               ADDR_DIV_HI:  rd = state_in.divider[15:8];
               ADDR_COUNTER: rd = state_in.counter;
               ADDR_MODULO:  rd = state_in.modulo;
               ADDR_CONTROL: rd = {5'b00000, state_in.control};
               default:      rd = READ_IDLE;
            endcase
         end
         OP_WRITE: begin
            case (addr)
               ADDR_DIV_LO, ADDR_DIV_HI: pre.divider = '0;
               ADDR_COUNTER: begin
                  // Load the counter and cancel a pending reload, unless the reload is already due
                  if (state_in.overflow_ticks < TICK_RELOAD) begin
                     pre.in_overflow    = 1'b0;
                     pre.counter        = write_data;
                     pre.overflow_ticks = 3'd0;
                  end
               end
               ADDR_MODULO: pre.modulo = write_data;
               ADDR_CONTROL: begin
                  pre.control = write_data[2:0];
                  do_step     = 1'b1;
               end
               default: pre = state_in;
            endcase
         end
         default: pre = state_in;
      endcase

      // On a tick or a control write, run one timer step on the updated divider and control
      nxt     = pre;
      irq     = 1'b0;
      sel_bit = pre.divider[sel_index(pre.control[1:0])];
      gate    = pre.control[CTRL_ENABLE] & sel_bit;
      ticks   = pre.overflow_ticks + 3'd1;
      if (do_step) begin
         if (!pre.in_overflow) begin
            if (!gate && pre.prior_gate) begin
               if (pre.counter == COUNTER_MAX) begin
                  nxt.counter     = 8'h00;
                  nxt.in_overflow = 1'b1;
               end else begin
                  nxt.counter = pre.counter + 8'd1;
               end
            end
         end else begin
            nxt.overflow_ticks = ticks;
            if (ticks == TICK_RELOAD) begin
               nxt.counter = pre.modulo;
               irq         = 1'b1;
            end else if (ticks == TICK_RESUME) begin
               nxt.counter        = pre.modulo;
               nxt.in_overflow    = 1'b0;
               nxt.overflow_ticks = 3'd0;
            end
         end
         nxt.prior_gate = gate;
      end
   end

   assign state_out          = nxt;
   assign result.read_data   = rd;
   assign result.irq_request = irq;

endmodule

// ===== rtl/divider_timer_with_overflow_reload_core.sv =====
// Divider timer with delayed overflow reload: top level with channel registers.
//
// Usage: each request transaction is a tick (op 0), a register read (op 1) or a
// register write (op 2) at addr with write_data. Every request gives exactly
// one response transaction carrying read_data (0xFF unless a mapped read) and
// irq_request, raised on the step that first reloads the counter from modulo
// after an overflow.
// Path: a taken request is held in the request register, passes through the
// combinational step logic and is registered in the response register once that
// has room, from which it shows on the response channel until it is taken.
// Throughput: one transaction per cycle while responses are taken; the state
// register loops through the step logic, so ticks can arrive back to back.
// Reset (synchronous, active high): both channel registers empty, divider 0xAB00,
// counter, modulo, control and overflow tracking cleared.
// Stall: while the response is not taken, the request register holds one more
// transaction and then ready drops; nothing is lost or repeated.
module divider_timer_with_overflow_reload_core
   import dtr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   dtr_req_if.sink        req_chan,
   dtr_rsp_if.source      rsp_chan
);

   logic           in_valid_ff;
   logic [1:0]     in_op_ff;
   logic [15:0]    in_addr_ff;
   logic [7:0]     in_data_ff;
   dtr_state_type  state_ff;
   dtr_state_type  state_in;
   logic           out_valid_ff;
   dtr_result_type out_result_ff;
   dtr_result_type step_result;
   logic           advance;
   logic           req_take;

   // Move the held request into the response register when it has room
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || !out_valid_ff || rsp_chan.ready;

   dtr_step u_step (
      .op         (in_op_ff),
      .addr       (in_addr_ff),
      .write_data (in_data_ff),
      .state_in   (state_ff),
      .state_out  (state_in),
      .result     (step_result)
   );

   // Hold the request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_chan.op;
         in_addr_ff <= req_chan.addr;
         in_data_ff <= req_chan.write_data;
      end
   end

   // Advance the timer state once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Hold the response until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.read_data   = out_result_ff.read_data;
   assign rsp_chan.irq_request = out_result_ff.irq_request;

endmodule

// ===== rtl/dtr_checker.sv =====
// Port-level checker of the divider timer and its bind to the top level.
`include "divider_timer_with_overflow_reload_core_defines.svh"

module dtr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_irq_request
);

   logic rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   // Drop any response after reset
   `DTR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // Keep accepting while the response side is empty
   `DTR_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   // An interrupt response never carries read data
   `DTR_ASSERT_IMPLY(a_irq_not_read, clock, reset, rsp_valid && rsp_irq_request, rsp_read_data == 8'hFF)
   // The reload interrupt cannot fire on two responses in a row
   `DTR_ASSERT_NEXT(a_irq_single, clock, reset, rsp_take && rsp_irq_request, !(rsp_take && rsp_irq_request))
   // Hold a stalled response
   `DTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_request))

endmodule

bind divider_timer_with_overflow_reload_core dtr_checker u_dtr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_read_data   (rsp_chan.read_data),
   .rsp_irq_request (rsp_chan.irq_request)
);
